// File: hw/rtl/ffa_pkg.sv
// shared constants and types for the first-fit block record allocator
package ffa_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned AddrW        = 32;
  localparam int unsigned SizeW        = 32;
  localparam int unsigned InDataW      = 64;
  localparam int unsigned OutDataW     = 40;

  localparam logic ActAlloc   = 1'b0;
  localparam logic ActRelease = 1'b1;

  typedef struct packed {
    logic             freed;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] addr;
  } rec_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ffa_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } ffa_sts_t;

endpackage

// File: hw/rtl/first_fit_block_record_allocator.sv
// a request scans the used records (up to 4096) in order
// the single read port of the record memory sets the scan at one record per cycle
// requests: one at a time, a new one accepted in the cycle after the last commit
// reset: record count cleared, break pointer at zero, record memory left unwritten
// a configuration write reloads the break pointer from the written base address
module first_fit_block_record_allocator import ffa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [AddrW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // request_size, release_address
  input  logic                s_axis_tuser_i,  // action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // block_address, reused, release_matched,
                                               // out_of_space, zero pad
);

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  ffa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// File: hw/rtl/ffa_ctrl.sv
// request sequencer: accept, scan, commit and result handoff
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid_i,
  output logic     s_axis_tready_o,
  output logic     m_axis_tvalid_o,
  input  logic     m_axis_tready_i,
  output ffa_cmd_t cmd_o,
  input  ffa_sts_t sts_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_vld_q;

  always_comb begin
    cmd_o.start  = s_axis_tvalid_i && (state_q == StIdle);
    cmd_o.scan   = (state_q == StScan);
    // the result slot must be free or emptying this cycle
    cmd_o.commit = (state_q == StFinish) && (!out_vld_q || m_axis_tready_i);

    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.start) state_d = StScan;
      end
      StScan: begin
        if (sts_i.hit || sts_i.exhausted) state_d = StFinish;
      end
      StFinish: begin
        if (cmd_o.commit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase

    if (cmd_o.commit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_axis_tvalid_o)
    else $error("result not presented after commit");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !cmd_o.commit)
    else $error("commit over a pending result");

endmodule

// File: hw/rtl/ffa_dp.sv
// record memory, break pointer, scan pipeline and result register
module ffa_dp import ffa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [AddrW-1:0]    cfg_wdata_i,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tuser_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  ffa_cmd_t            cmd_i,
  output ffa_sts_t            sts_o
);

  rec_t             mem_q [TableEntries];
  rec_t             rd_data_q;

  logic             action_q;
  logic [SizeW-1:0] size_q;
  logic [AddrW-1:0] rel_q;
  logic [CntW-1:0]  count_q;
  logic [AddrW-1:0] brk_q;
  logic [CntW-1:0]  limit_q, limit_d;
  logic [CntW-1:0]  rd_cnt_q;
  logic             chk_vld_q;
  logic [IdxW-1:0]  chk_idx_q;
  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  rec_t             hit_rec_q;

  logic [AddrW-1:0] res_addr_q;
  logic             res_reused_q, res_matched_q, res_oos_q;

  logic             issue, match, oos, we;
  logic [IdxW-1:0]  rd_idx, wr_idx;
  rec_t             wr_data;
  logic [AddrW:0]   sum;
  logic [AddrW-1:0] res_addr_d;

  assign rd_idx = rd_cnt_q[IdxW-1:0];

  always_comb begin
    // a full table wraps to zero for an allocate
    if (s_axis_tuser_i == ActRelease) begin
      limit_d = count_q;
    end else if (count_q == CntW'(TableEntries)) begin
      limit_d = '0;
    end else begin
      limit_d = count_q;
    end

    if (action_q == ActRelease) begin
      match = (rd_data_q.addr == rel_q);
    end else begin
      match = rd_data_q.freed && (rd_data_q.size >= size_q);
    end

    sts_o.hit       = chk_vld_q && match;
    sts_o.exhausted = !chk_vld_q && (rd_cnt_q == limit_q);
    issue           = cmd_i.scan && (rd_cnt_q < limit_q) && !sts_o.hit;

    sum = {1'b0, brk_q} + {1'b0, size_q};
    oos = (action_q == ActAlloc) && !hit_q && sum[AddrW];
    we  = cmd_i.commit && (hit_q || ((action_q == ActAlloc) && !sum[AddrW]));

    if (hit_q) begin
      wr_idx        = hit_idx_q;
      wr_data.freed = action_q;
      wr_data.size  = hit_rec_q.size;
      wr_data.addr  = hit_rec_q.addr;
    end else begin
      wr_idx        = limit_q[IdxW-1:0];
      wr_data.freed = 1'b0;
      wr_data.size  = size_q;
      wr_data.addr  = brk_q;
    end

    if (action_q == ActRelease || oos) begin
      res_addr_d = '0;
    end else if (hit_q) begin
      res_addr_d = hit_rec_q.addr;
    end else begin
      res_addr_d = brk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_idx] <= wr_data;
    rd_data_q <= mem_q[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      action_q <= s_axis_tuser_i;
      size_q   <= s_axis_tdata_i[SizeW-1:0];
      rel_q    <= s_axis_tdata_i[InDataW-1:SizeW];
    end
    chk_idx_q <= rd_idx;
    if (cmd_i.scan && sts_o.hit) begin
      hit_idx_q <= chk_idx_q;
      hit_rec_q <= rd_data_q;
    end
    if (cmd_i.commit) begin
      res_addr_q    <= res_addr_d;
      res_reused_q  <= (action_q == ActAlloc) && hit_q;
      res_matched_q <= (action_q == ActRelease) && hit_q;
      res_oos_q     <= oos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      brk_q     <= '0;
      limit_q   <= '0;
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      chk_vld_q <= issue;
      if (cmd_i.start) begin
        limit_q  <= limit_d;
        rd_cnt_q <= '0;
        hit_q    <= 1'b0;
      end else begin
        if (issue) rd_cnt_q <= rd_cnt_q + 1'b1;
        if (cmd_i.scan && sts_o.hit) hit_q <= 1'b1;
      end
      if (cfg_we_i) begin
        brk_q <= cfg_wdata_i;
      end else if (cmd_i.commit && action_q == ActAlloc) begin
        if (hit_q) begin
          count_q <= limit_q;
        end else if (!sum[AddrW]) begin
          count_q <= limit_q + 1'b1;
          brk_q   <= sum[AddrW-1:0];
        end
      end
    end
  end

  assign m_axis_tdata_o = {5'b0, res_oos_q, res_matched_q, res_reused_q, res_addr_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableEntries))
    else $error("record count beyond table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= limit_q)
    else $error("scan ran past used records");

  a_hit_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts_o.hit && sts_o.exhausted))
    else $error("hit and exhausted together");

  a_oos_keeps_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && oos && !cfg_we_i) |=> $stable(brk_q) && $stable(count_q))
    else $error("state changed on out of space");

endmodule
